FILE: design/in_order_release_buffer_core_macros.svh
// Assertion macros used by the checker file
`ifndef IN_ORDER_RELEASE_BUFFER_CORE_MACROS_SVH
`define IN_ORDER_RELEASE_BUFFER_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset
`define IORB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iorb: implication check failed");

// Next-cycle implication checked outside reset
`define IORB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iorb: next-cycle check failed");

`endif

FILE: design/iorb_pkg.sv
`default_nettype none
package iorb_pkg;

   localparam int MAX_ENTRIES   = 64;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int ID_WIDTH      = 7;
   localparam int VALUE_WIDTH   = 32;
   localparam int SLOT_WIDTH    = $clog2(MAX_ENTRIES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QIDX_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ID_WIDTH-1:0] LEN_RESET = ID_WIDTH'(64);
   localparam logic [ID_WIDTH-1:0] LEN_MAX   = ID_WIDTH'(MAX_ENTRIES);
   localparam logic [ID_WIDTH-1:0] ID_FIRST  = ID_WIDTH'(1);

   typedef struct packed {
      logic [ID_WIDTH-1:0]      id;
      logic [PAYLOAD_WIDTH-1:0] value;
      logic [ID_WIDTH-1:0]      len;
   } iorb_item_type;

   typedef struct packed {
      logic          valid;
      iorb_item_type item;
   } iorb_push_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CHECK,
      BACK_EMIT
   } iorb_back_state_type;

endpackage
`default_nettype wire

FILE: design/in_order_release_buffer_core.sv
// In-order release buffer. An item (req_entry_id, req_entry_value) is taken on a
// rising edge with start high and busy low; identifiers outside 1 .. stream length,
// or already released, are dropped silently. Results come out in identifier order on
// rsp_* for exactly one cycle each, marked by rsp_strobe, and the receiver cannot
// stall them; rsp_run_last flags the final result caused by an insert. Items inside
// the stream length wait in a two-entry queue, and busy is high while it is full;
// an identifier outside the length never enters the queue. The release sequencer
// handles each stored item with a payload write, then a check of the release
// pointer, and then releases one entry per cycle; an item dropped as already
// released is only popped from the queue. The stream length register (csr_*) must
// only be written while no item is in flight.
`default_nettype none
module in_order_release_buffer_core
   import iorb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [ID_WIDTH-1:0]    req_entry_id,
   input  wire logic [VALUE_WIDTH-1:0] req_entry_value,
   input  wire logic                   csr_write_enable,
   input  wire logic [ID_WIDTH-1:0]    csr_write_data,
   output logic                        rsp_strobe,
   output logic [VALUE_WIDTH-1:0]      rsp_released_value,
   output logic [ID_WIDTH-1:0]         rsp_released_id,
   output logic                        rsp_run_last
);

   iorb_push_type push;
   iorb_item_type head;
   logic          queue_full;
   logic          not_empty;
   logic          pop;

   iorb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_entry_id     (req_entry_id),
      .req_entry_value  (req_entry_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .busy             (busy)
   );

   iorb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (not_empty),
      .head      (head)
   );

   iorb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (not_empty),
      .q_item             (head),
      .q_pop              (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_released_value (rsp_released_value),
      .rsp_released_id    (rsp_released_id),
      .rsp_run_last       (rsp_run_last)
   );

endmodule
`default_nettype wire

FILE: design/iorb_front.sv
`default_nettype none
module iorb_front
   import iorb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [ID_WIDTH-1:0]    req_entry_id,
   input  wire logic [VALUE_WIDTH-1:0] req_entry_value,
   input  wire logic                   csr_write_enable,
   input  wire logic [ID_WIDTH-1:0]    csr_write_data,
   input  wire logic                   queue_full,
   output iorb_push_type               push,
   output logic                        busy
);

   logic [ID_WIDTH-1:0] len_ff;
   logic [ID_WIDTH-1:0] len_in;
   logic [ID_WIDTH-1:0] eff_len;
   logic                accept;

   // hold the stream length register
   always_comb begin
      len_in = len_ff;
      if (csr_write_enable) begin
         len_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   // clamp the length into 1 .. MAX_ENTRIES
   always_comb begin
      eff_len = len_ff;
      if (len_ff < ID_FIRST) begin
         eff_len = ID_FIRST;
      end else if (len_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end
   end

   // classify: pass in-range identifiers on, drop the rest
   assign accept          = start && !queue_full;
   assign busy            = queue_full;
   assign push.valid      = accept && (req_entry_id >= ID_FIRST) && (req_entry_id <= eff_len);
   assign push.item.id    = req_entry_id;
   assign push.item.value = PAYLOAD_WIDTH'(req_entry_value);
   assign push.item.len   = eff_len;

endmodule
`default_nettype wire

FILE: design/iorb_queue.sv
`default_nettype none
module iorb_queue
   import iorb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  iorb_push_type push,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output iorb_item_type head
);

   iorb_item_type             entries_ff [QUEUE_DEPTH];
   logic [QIDX_WIDTH-1:0]     wr_idx_ff;
   logic [QIDX_WIDTH-1:0]     wr_idx_in;
   logic [QIDX_WIDTH-1:0]     rd_idx_ff;
   logic [QIDX_WIDTH-1:0]     rd_idx_in;
   logic [QCNT_WIDTH-1:0]     count_ff;
   logic [QCNT_WIDTH-1:0]     count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_idx_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   // advance the pointers with wrap
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_idx_in = (wr_idx_ff == QIDX_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (do_pop) begin
         rd_idx_in = (rd_idx_ff == QIDX_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_idx_ff] <= push.item;
      end
   end

endmodule
`default_nettype wire

FILE: design/iorb_back.sv
`default_nettype none
module iorb_back
   import iorb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  iorb_item_type               q_item,
   output logic                        q_pop,
   output logic                        rsp_strobe,
   output logic [VALUE_WIDTH-1:0]      rsp_released_value,
   output logic [ID_WIDTH-1:0]         rsp_released_id,
   output logic                        rsp_run_last
);

   iorb_back_state_type          state_ff;
   iorb_back_state_type          state_in;
   logic [ID_WIDTH-1:0]          ptr_ff;
   logic [ID_WIDTH-1:0]          ptr_in;
   logic [ID_WIDTH-1:0]          len_ff;
   logic [ID_WIDTH-1:0]          len_in;
   logic [MAX_ENTRIES-1:0]       valid_ff;
   logic [MAX_ENTRIES-1:0]       valid_in;
   logic [PAYLOAD_WIDTH-1:0]     payload_mem_ff [MAX_ENTRIES];
   logic [PAYLOAD_WIDTH-1:0]     rd_data_ff;
   logic [ID_WIDTH-1:0]          ptr_m1;
   logic [ID_WIDTH-1:0]          wr_id_m1;
   logic [SLOT_WIDTH-1:0]        wr_slot;
   logic [SLOT_WIDTH-1:0]        rd_slot;
   logic                         mem_we;
   logic                         head_hit;
   logic                         chk_hit;
   logic                         nxt_hit;

   assign ptr_m1   = ptr_ff - ID_FIRST;
   assign wr_id_m1 = q_item.id - ID_FIRST;
   assign wr_slot  = wr_id_m1[SLOT_WIDTH-1:0];

   // an insert counts only if its slot has not been released yet
   assign head_hit = q_valid && (q_item.id >= ptr_ff);
   assign chk_hit  = (ptr_ff <= len_ff) && valid_ff[ptr_m1[SLOT_WIDTH-1:0]];
   assign nxt_hit  = (ptr_ff < len_ff) && valid_ff[ptr_ff[SLOT_WIDTH-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE:  state_in = head_hit ? BACK_CHECK : BACK_IDLE;
         BACK_CHECK: state_in = chk_hit ? BACK_EMIT : BACK_IDLE;
         BACK_EMIT:  state_in = nxt_hit ? BACK_EMIT : BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rsp_strobe   = 1'b0;
      rsp_run_last = 1'b0;
      rd_slot      = ptr_m1[SLOT_WIDTH-1:0];
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      case (state_ff)
         BACK_IDLE: begin
            q_pop  = q_valid;
            mem_we = head_hit;
            if (head_hit) begin
               len_in = q_item.len;
            end
         end
         BACK_CHECK: begin
            rd_slot = ptr_m1[SLOT_WIDTH-1:0];
         end
         BACK_EMIT: begin
            rsp_strobe   = 1'b1;
            rsp_run_last = !nxt_hit;
            rd_slot      = ptr_ff[SLOT_WIDTH-1:0];
            ptr_in       = ptr_ff + ID_FIRST;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // mark written slots valid
   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         ptr_ff   <= ID_FIRST;
         len_ff   <= LEN_RESET;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   // payload store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem_ff[wr_slot] <= q_item.value;
      end
      rd_data_ff <= payload_mem_ff[rd_slot];
   end

   assign rsp_released_value = VALUE_WIDTH'(rd_data_ff);
   assign rsp_released_id    = ptr_ff;

endmodule
`default_nettype wire

FILE: design/iorb_checker.sv
`default_nettype none
`include "in_order_release_buffer_core_macros.svh"
module iorb_checker
   import iorb_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_strobe,
   input wire logic [ID_WIDTH-1:0] rsp_released_id,
   input wire logic                rsp_run_last
);

   // a run continues without gaps until its last transfer
   `IORB_ASSERT_NEXT(a_run_contiguous, clock, reset, rsp_strobe && !rsp_run_last, rsp_strobe)

   // identifiers within a run step by one
   `IORB_ASSERT_NEXT(a_run_in_order, clock, reset, rsp_strobe && !rsp_run_last, rsp_released_id == ID_WIDTH'($past(rsp_released_id) + ID_FIRST))

   // the cycle after a run ends carries no transfer
   `IORB_ASSERT_NEXT(a_run_gap, clock, reset, rsp_strobe && rsp_run_last, !rsp_strobe)

   // released identifiers stay inside the slot range
   `IORB_ASSERT_IMP(a_id_range, clock, reset, rsp_strobe, (rsp_released_id != '0) && (rsp_released_id <= LEN_MAX))

endmodule

bind in_order_release_buffer_core iorb_checker u_iorb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_released_id (rsp_released_id),
   .rsp_run_last    (rsp_run_last)
);
`default_nettype wire
